>>> hdl/isl_pkg.sv
package isl_pkg;

  // list geometry
  localparam int CAPACITY      = 16;
  localparam int ELEMENT_WIDTH = 32;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  // width used when comparing an index against a position or the count
  localparam int CMP_W         = (CNT_W > 5) ? CNT_W : 5;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [CMP_W-1:0]         cmp_t;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_READ      = 3'd3,
    OP_OVERWRITE = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cell control for the current cycle
  typedef struct packed {
    logic load;        // take the incoming word
    logic take_left;   // shift up: take lower neighbor
    logic take_right;  // shift down: take upper neighbor
    logic read_sel;    // drive entry onto the read tap
  } cell_cmd_t;

endpackage

>>> hdl/isl_cell.sv
module isl_cell import isl_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  elem_t     word_in,
  input  elem_t     left,
  input  elem_t     right,
  output elem_t     entry,
  output elem_t     tap
);

  // one list slot: load, shift up, shift down or hold
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry <= word_in;
    end else if (cmd.take_left) begin
      entry <= left;
    end else if (cmd.take_right) begin
      entry <= right;
    end
  end

  // gated read contribution, OR-combined at the top
  assign tap = cmd.read_sel ? entry : '0;

endmodule

>>> hdl/indexed_shift_list.sv
// Ordered list of up to CAPACITY signed words held in a row of cells.
// Input channel (item_valid / item_stall): operation, index, value. One
// word is one operation: append, insert at index, remove at index, read,
// overwrite, clear. Insert shifts every cell above the index up by one,
// remove shifts them down by one, all in the same cycle.
// Output channel (result_valid / result_stall): read_value, status,
// entry_count, is_empty; exactly one result word per input word.
// The result word is registered as its input is accepted.
// Throughput: one operation per cycle while item_stall is low; all cells
// update as it is accepted, so the next operation sees the new list.
// The result register is the only buffer: while it holds a word that the
// receiver stalls, item_stall is high and no new operation is taken.
// Reset clears the entry count and the result valid flag; cell contents
// are undefined but never visible, since only slots below the count are
// read.
module indexed_shift_list import isl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  operation,
  input  logic [4:0]  index,
  input  logic [31:0] value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] read_value,
  output logic [1:0]  status,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  count_t    fill_count;
  count_t    fill_count_next;
  status_t   st_next;
  status_t   status_reg;
  logic [31:0] read_value_reg;
  logic [31:0] rd_next;
  count_t    count_reg;
  logic      accept;
  logic      full;
  cmp_t      idx_c;
  cmp_t      fill_c;
  elem_t     word_in;
  logic [63:0] val_wide;
  logic [63:0] rd_wide;
  elem_t     rd_elem;
  elem_t     entries [CAPACITY];
  elem_t     taps    [CAPACITY];
  cell_cmd_t cmds    [CAPACITY];
  logic      do_load_at_idx;
  logic      do_append;
  logic      do_shift_up;
  logic      do_shift_down;
  logic      do_read;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign idx_c    = CMP_W'(index);
  assign fill_c   = CMP_W'(fill_count);
  assign full     = (fill_count == count_t'(CAPACITY));
  assign val_wide = {32'b0, value};
  assign word_in  = val_wide[ELEMENT_WIDTH-1:0];

  // decode the operation into list-wide actions and the new count
  always_comb begin
    fill_count_next = fill_count;
    st_next         = ST_OK;
    do_load_at_idx  = 1'b0;
    do_append       = 1'b0;
    do_shift_up     = 1'b0;
    do_shift_down   = 1'b0;
    do_read         = 1'b0;
    case (operation)
      OP_APPEND: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          do_append       = 1'b1;
          fill_count_next = fill_count + count_t'(1);
        end
      end
      OP_INSERT: begin
        if (idx_c > fill_c) begin
          st_next = ST_RANGE;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          do_shift_up     = 1'b1;
          do_load_at_idx  = 1'b1;
          fill_count_next = fill_count + count_t'(1);
        end
      end
      OP_REMOVE: begin
        if (idx_c >= fill_c) begin
          st_next = ST_RANGE;
        end else begin
          do_shift_down   = 1'b1;
          fill_count_next = fill_count - count_t'(1);
        end
      end
      OP_READ: begin
        if (idx_c >= fill_c) begin
          st_next = ST_RANGE;
        end else begin
          do_read = 1'b1;
        end
      end
      OP_OVERWRITE: begin
        if (idx_c >= fill_c) begin
          st_next = ST_RANGE;
        end else begin
          do_load_at_idx = 1'b1;
        end
      end
      OP_CLEAR: begin
        fill_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // per-cell commands from the position compares
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmds[i].load       = accept && ((do_load_at_idx && idx_c == CMP_W'(i)) ||
                                      (do_append && fill_c == CMP_W'(i)));
      cmds[i].take_left  = accept && do_shift_up && (CMP_W'(i) > idx_c);
      cmds[i].take_right = accept && do_shift_down && (CMP_W'(i) >= idx_c);
      cmds[i].read_sel   = do_read && (idx_c == CMP_W'(i));
    end
  end

  // the cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    elem_t left_w;
    elem_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entries[g+1];
    end
    isl_cell u_cell (
      .clk     (clk),
      .cmd     (cmds[g]),
      .word_in (word_in),
      .left    (left_w),
      .right   (right_w),
      .entry   (entries[g]),
      .tap     (taps[g])
    );
  end

  // read tap: at most one cell drives a nonzero word
  always_comb begin
    rd_elem = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_elem = rd_elem | taps[i];
    end
  end

  assign rd_wide = 64'(signed'(rd_elem));
  assign rd_next = rd_wide[31:0];

  // entry count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill_count   <= fill_count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_reg <= rd_next;
      status_reg     <= st_next;
      count_reg      <= fill_count_next;
    end
  end

  assign read_value  = read_value_reg;
  assign status      = status_reg;
  assign entry_count = count_reg[4:0];
  assign is_empty    = (count_reg == '0);

endmodule

>>> verif/indexed_shift_list_tb.sv
module indexed_shift_list_tb import isl_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // expected contents of one result word
  typedef struct {
    logic [31:0] read_value;
    status_t     status;
    logic [4:0]  entry_count;
    logic        is_empty;
  } list_result_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  logic [2:0]  operation    = 3'd0;
  logic [4:0]  index        = 5'd0;
  logic [31:0] value        = 32'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  logic        is_empty;

  // shadow copy of the list
  elem_t list_mem [CAPACITY];
  int    list_len = 0;

  list_result_t pending_results [$];
  int  mismatch_count = 0;
  bit  gaps_on   = 1'b1;
  bit  stalls_on = 1'b1;

  indexed_shift_list i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .index        (index),
    .value        (value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .read_value   (read_value),
    .status       (status),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  always #6 clk = ~clk;

  // apply one operation to the shadow list, return the word it should produce
  function automatic list_result_t apply_list_op(op_t op, logic [4:0] idx, logic [31:0] val);
    list_result_t r;
    int pos;
    int at;
    at = int'(idx);
    r.read_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        // a bad index wins over full
        if (at > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (pos = list_len; pos > at; pos--) list_mem[pos] = list_mem[pos-1];
          list_mem[at] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (at >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (pos = at; pos + 1 < list_len; pos++) list_mem[pos] = list_mem[pos+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (at >= list_len) r.status = ST_RANGE;
        else r.read_value = list_mem[at];
      end
      OP_OVERWRITE: begin
        if (at >= list_len) r.status = ST_RANGE;
        else list_mem[at] = val;
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.entry_count = 5'(list_len);
    r.is_empty    = (list_len == 0);
    return r;
  endfunction

  // send one word, with random idle cycles ahead of it when gaps are on
  task automatic send_word(input op_t op, input logic [4:0] idx, input logic [31:0] val);
    while (gaps_on && ($urandom_range(99) < 8)) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    index      <= idx;
    value      <= val;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(apply_list_op(op, idx, val));
  endtask

  // hold off until every outstanding result word has come back
  task automatic wait_results_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // result side: random stall, compare each accepted word
  always @(posedge clk) begin
    list_result_t exp_r;
    result_stall <= stalls_on && ($urandom_range(99) < 8);
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (read_value !== exp_r.read_value) begin
          $error("read_value: expected %0d, got %0d",
                 $signed(exp_r.read_value), $signed(read_value));
          mismatch_count++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          mismatch_count++;
        end
        if (entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, entry_count);
          mismatch_count++;
        end
        if (is_empty !== exp_r.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_r.is_empty, is_empty);
          mismatch_count++;
        end
      end
    end
  end

  // on an empty list, read, remove, overwrite and insert past the end are out of range; insert at 0 works
  task automatic test_empty_list();
    send_word(OP_READ,      5'd0, 32'd0);
    send_word(OP_REMOVE,    5'd0, 32'd0);
    send_word(OP_OVERWRITE, 5'd0, 32'h1234_5678);
    send_word(OP_INSERT,    5'd1, 32'h1);
    send_word(OP_CLEAR,     5'd0, 32'd0);
    send_word(OP_INSERT,    5'd0, 32'h8000_0000);
  endtask

  // fill up, hit full, then work both ends of a full list
  task automatic test_full_list();
    int k;
    send_word(OP_APPEND, 5'd0, 32'h7fff_ffff);
    send_word(OP_APPEND, 5'd0, 32'hffff_ffff);
    for (k = 3; k < CAPACITY; k++) send_word(OP_APPEND, 5'($urandom), $urandom);
    send_word(OP_APPEND,    5'd0,  32'd0);
    send_word(OP_INSERT,    5'd16, 32'd5);
    send_word(OP_INSERT,    5'd0,  32'd6);
    send_word(OP_READ,      5'd15, 32'd0);
    send_word(OP_READ,      5'd16, 32'd0);
    send_word(OP_OVERWRITE, 5'd15, 32'hffff_ffff);
    send_word(OP_REMOVE,    5'd16, 32'd0);
    send_word(OP_REMOVE,    5'd15, 32'd0);
    send_word(OP_INSERT,    5'd15, 32'h8000_0000);
    send_word(OP_REMOVE,    5'd0,  32'd0);
    send_word(OP_READ,      5'd0,  32'd0);
    send_word(OP_CLEAR,     5'd0,  32'd0);
    send_word(OP_READ,      5'd0,  32'd0);
  endtask

  // random mix; phases lean toward growing or shrinking so both ends are hit
  task automatic test_random_ops(input int count);
    int k;
    int roll;
    bit shrink;
    op_t op;
    logic [4:0] idx;
    logic [31:0] val;
    shrink = 1'b0;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) shrink = ($urandom_range(99) < 35);
      roll = $urandom_range(99);
      if (shrink) begin
        if (roll < 10)      op = OP_APPEND;
        else if (roll < 18) op = OP_INSERT;
        else if (roll < 55) op = OP_REMOVE;
        else if (roll < 75) op = OP_READ;
        else if (roll < 97) op = OP_OVERWRITE;
        else                op = OP_CLEAR;
      end else begin
        if (roll < 35)      op = OP_APPEND;
        else if (roll < 60) op = OP_INSERT;
        else if (roll < 70) op = OP_REMOVE;
        else if (roll < 82) op = OP_READ;
        else if (roll < 97) op = OP_OVERWRITE;
        else                op = OP_CLEAR;
      end
      // mostly legal positions, sometimes any position from 0 to 16
      if ($urandom_range(99) < 85) begin
        if (op == OP_INSERT || list_len == 0) idx = 5'($urandom_range(list_len));
        else idx = 5'($urandom_range(list_len - 1));
      end else begin
        idx = 5'($urandom_range(16));
      end
      case ($urandom_range(9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = 32'd0;
        3:       val = 32'hffff_ffff;
        default: val = $urandom;
      endcase
      send_word(op, idx, val);
    end
  endtask

  // a long stretch with no idling on either side
  task automatic test_back_to_back(input int count);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_ops(count);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_full_list();
    test_random_ops(650);
    wait_results_drained();
    test_back_to_back(300);
    test_random_ops(400);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("indexed_shift_list_tb passed");
    end else begin
      $display("indexed_shift_list_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("indexed_shift_list_tb failed");
    $finish;
  end

endmodule
